// File: sv/byte_ring_fifo_entry_pointers_defines.svh
// ----------------------------------------------------------------------------
// Byte ring FIFO assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_ENTRY_POINTERS_DEFINES_SVH
`define BYTE_RING_FIFO_ENTRY_POINTERS_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge.
`define BRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("byte ring fifo check failed");
// Check that a condition is followed by an outcome in the next cycle.
`define BRF_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("byte ring fifo sequence check failed");
`else
`define BRF_ASSERT(lbl, prop)
`define BRF_ASSERT_NEXT(lbl, cond, expr)
`endif

`endif

// File: sv/brf_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Field widths, stream packing, codes and defaults for the byte ring FIFO.
// ----------------------------------------------------------------------------
package brf_pkg;

  // Pointer header: two 4-byte pointers ahead of the data region
  localparam int PTR_WORD_BYTES = 4;
  localparam int HEADER_BYTES   = 2 * PTR_WORD_BYTES;
  localparam int MIN_MEM        = 16;

  // Parameter defaults
  localparam int MEM_BYTES_DEF = 1024;
  localparam int MAX_XFER_DEF  = 64;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int USED_W  = 10;
  localparam int MEMSZ_W = 11;
  localparam int ESZ_W   = 2;

  // Stream and configuration port widths
  localparam int S_TDATA_W  = 16;
  localparam int S_TUSER_W  = 3;
  localparam int M_TDATA_W  = 24;
  localparam int M_TUSER_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = MEMSZ_W;

  localparam logic [MEMSZ_W-1:0] MEMSZ_RESET = 11'd1024;

  // Request kinds
  localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LOG2 = 2'd1;

  // Result status
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NO_DATA  = 2'd2,
    ST_BAD_LEN  = 2'd3
  } status_t;

endpackage

// File: sv/byte_ring_fifo_entry_pointers.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO with entry-granular pointers
// Byte FIFO in a single-port ring store; pointers kept in entry units.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: write one byte (tuser first marks the start of a
//   run, whose length comes with it), read (consume) or peek a length of
//   bytes. m_* returns results with status, byte and used count; tlast
//   marks the final result of a request. cfg_* writes mem_size and
//   entry_size_log2; a write to either of them re-initializes both pointers.
// Flow:
//   Write bytes are taken one per cycle while the output slot is free and
//   no register write is pending, and stored as they arrive; the last byte
//   of a run enters S_WDONE, which loads its result and holds off the next
//   request. A read or peek of N bytes streams N results one per cycle when
//   the receiver keeps up: each byte goes from the ring store into the
//   holding register, then the output register; new requests wait until the
//   last byte moves on. Errors load the output in the cycle after acceptance.
// Reset:
//   rst resets pointers, run state, both registers and the output valid flag; the ring store
//   is not cleared and needs no clearing pass.
// Stall:
//   Results sit in one output register with a read-data holding register
//   behind it; a stalled m_tready stops reads and new requests.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_entry_pointers_defines.svh"

module byte_ring_fifo_entry_pointers #(
  parameter int MEM_BYTES = brf_pkg::MEM_BYTES_DEF,
  parameter int MAX_XFER  = brf_pkg::MAX_XFER_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [brf_pkg::S_TDATA_W-1:0]  s_tdata,   // [6:0] length, [14:7] data_byte, [15] 0
  input  logic [brf_pkg::S_TUSER_W-1:0]  s_tuser,   // [1:0] func, [2] first
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [brf_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] read_byte, [17:8] used_bytes, [23:18] 0
  output logic [brf_pkg::M_TUSER_W-1:0]  m_tuser,   // [1:0] status
  output logic                           m_tlast,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [brf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [brf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import brf_pkg::*;

  localparam int AW  = $clog2(MEM_BYTES);
  localparam int EW  = $clog2(MEM_BYTES + 1);
  localparam int EW1 = EW + 1;
  localparam int CW  = (EW > MEMSZ_W) ? EW : MEMSZ_W;
  localparam int SW  = EW + 8;
  localparam int PAD_W = M_TDATA_W - USED_W - BYTE_W;

  typedef enum logic [1:0] {S_IDLE, S_WDONE, S_RD} state_t;

  // Step a byte address with wrap back to the start of the data region
  function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a,
                                              input logic [EW-1:0] eff);
    logic [EW-1:0] a1;
    a1 = EW'(a) + EW'(1);
    return (a1 >= eff) ? AW'(HEADER_BYTES) : AW'(a1);
  endfunction

  // Registers
  state_t                state;
  logic [MEMSZ_W-1:0]    mem_size;
  logic [ESZ_W-1:0]      esz_log2;
  logic [AW-1:0]         wptr;
  logic [AW-1:0]         rptr;
  logic [LEN_W-1:0]      run_rem;
  logic                  run_acc;
  logic [AW-1:0]         run_addr;
  logic [AW-1:0]         raddr;
  logic [LEN_W-1:0]      issue_rem;
  logic                  rd_pend;
  logic                  rd_last;
  logic [BYTE_W-1:0]     rd_q;
  logic                  out_valid;
  status_t               out_status;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_last;
  logic [USED_W-1:0]     out_used;

  // Ring store
  logic [BYTE_W-1:0]     ring [MEM_BYTES];

  // Decoded request
  logic [LEN_W-1:0]      in_len;
  logic [BYTE_W-1:0]     in_byte;
  logic [FUNC_W-1:0]     in_func;
  logic                  in_first;

  logic [CW-1:0]         msz_ext;
  logic [CW-1:0]         eff_c;
  logic [EW-1:0]         eff;
  logic [EW-1:0]         region;
  logic [AW-1:0]         wbyte;
  logic [AW-1:0]         rbyte;
  logic [EW-1:0]         w_e;
  logic [EW-1:0]         r_e;
  logic [EW-1:0]         gap_bytes;
  logic [EW-1:0]         used;
  logic [3:0]            entry_bytes;
  logic                  bad_len;
  logic                  space_ok;
  logic                  data_ok;
  logic [EW1-1:0]        rd_sum;
  logic [AW-1:0]         rd_end;
  logic                  wr_acc_e;
  logic [LEN_W-1:0]      wr_rem_e;
  logic [AW-1:0]         wr_addr_e;
  logic [AW-1:0]         wr_addr_nx;
  logic                  wr_fin;
  logic                  accept;
  logic                  slot_free;
  logic                  mem_we;
  logic                  rd_move;
  logic                  rd_issue;
  logic                  out_load;
  logic                  out_valid_next;

  assign in_len   = s_tdata[LEN_W-1:0];
  assign in_byte  = s_tdata[LEN_W+BYTE_W-1:LEN_W];
  assign in_func  = s_tuser[FUNC_W-1:0];
  assign in_first = s_tuser[FUNC_W];

  // Clamp the ring size and derive the data region
  always_comb begin
    msz_ext = CW'(mem_size);
    if (msz_ext < CW'(MIN_MEM)) begin
      eff_c = CW'(MIN_MEM);
    end else if (msz_ext > CW'(MEM_BYTES)) begin
      eff_c = CW'(MEM_BYTES);
    end else begin
      eff_c = msz_ext;
    end
    eff    = EW'(eff_c);
    region = eff - EW'(HEADER_BYTES);
  end

  // Bytes held, from the entry pointers
  always_comb begin
    wbyte     = AW'(wptr << esz_log2);
    rbyte     = AW'(rptr << esz_log2);
    w_e       = EW'(wbyte);
    r_e       = EW'(rbyte);
    gap_bytes = r_e - w_e;
    if (w_e >= r_e) begin
      used = w_e - r_e;
    end else if (gap_bytes > region) begin
      used = '0;
    end else begin
      used = region - gap_bytes;
    end
    if (used > region) begin
      used = region;
    end
  end

  // Request checks and read end address
  always_comb begin
    entry_bytes = 4'd1 << esz_log2;
    bad_len  = (in_len == '0) || (in_len > LEN_W'(MAX_XFER));
    space_ok = (SW'(used) + SW'(entry_bytes) + SW'(in_len)) < SW'(region);
    data_ok  = SW'(in_len) <= SW'(used);
    rd_sum   = EW1'(rbyte) + EW1'(in_len);
    if (rd_sum >= EW1'(eff)) begin
      rd_end = AW'(rd_sum - EW1'(region));
    end else begin
      rd_end = AW'(rd_sum);
    end
  end

  // Write run: a first byte opens the run at the write pointer
  always_comb begin
    if (in_first) begin
      wr_acc_e  = 1'b1;
      wr_rem_e  = in_len;
      wr_addr_e = wbyte;
    end else begin
      wr_acc_e  = run_acc;
      wr_rem_e  = run_rem;
      wr_addr_e = run_addr;
    end
    wr_addr_nx = next_addr(wr_addr_e, eff);
    wr_fin     = wr_acc_e && (wr_rem_e == LEN_W'(1));
  end

  // Handshakes
  assign slot_free = !out_valid || m_tready;
  assign s_tready  = (state == S_IDLE) && slot_free && !cfg_valid;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign mem_we    = accept && (in_func == FN_WRITE) &&
                     (in_first ? (!bad_len && space_ok) : run_acc);
  assign rd_move   = rd_pend && slot_free;
  assign rd_issue  = (state == S_RD) && (issue_rem != '0) && (!rd_pend || rd_move);

  // Load a new result into the output register
  always_comb begin
    out_load = 1'b0;
    if (!cfg_valid) begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_func)
              FN_WRITE:         out_load = in_first && (bad_len || !space_ok);
              FN_READ, FN_PEEK: out_load = bad_len || !data_ok;
              default:          out_load = 1'b0;
            endcase
          end
        end
        S_WDONE: out_load = 1'b1;
        S_RD:    out_load = rd_move;
        default: out_load = 1'b0;
      endcase
    end
  end

  // Hold a result until taken
  assign out_valid_next = out_load || (out_valid && !m_tready);

  // Ring store: write on request, registered read into rd_q
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_addr_e] <= in_byte;
    end
    if (rd_issue) begin
      rd_q <= ring[raddr];
    end
  end

  // Sequencer, pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mem_size  <= MEMSZ_RESET;
      esz_log2  <= '0;
      wptr      <= AW'(HEADER_BYTES);
      rptr      <= AW'(HEADER_BYTES);
      run_rem   <= '0;
      run_acc   <= 1'b0;
      run_addr  <= '0;
      issue_rem <= '0;
      rd_pend   <= 1'b0;
      rd_last   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (cfg_valid) begin
        // register write re-initializes pointers and the run
        case (cfg_index)
          CFG_MEM_SIZE: begin
            mem_size <= cfg_data;
            wptr     <= AW'(HEADER_BYTES) >> esz_log2;
            rptr     <= AW'(HEADER_BYTES) >> esz_log2;
            run_rem  <= '0;
            run_acc  <= 1'b0;
            run_addr <= '0;
          end
          CFG_ENTRY_LOG2: begin
            esz_log2 <= cfg_data[ESZ_W-1:0];
            wptr     <= AW'(HEADER_BYTES) >> cfg_data[ESZ_W-1:0];
            rptr     <= AW'(HEADER_BYTES) >> cfg_data[ESZ_W-1:0];
            run_rem  <= '0;
            run_acc  <= 1'b0;
            run_addr <= '0;
          end
          default: ;
        endcase
      end else begin
        case (state)
          S_IDLE: begin
            if (accept) begin
              case (in_func)
                FN_WRITE: begin
                  if (in_first && bad_len) begin
                    run_rem    <= '0;
                    run_acc    <= 1'b0;
                    out_status <= ST_BAD_LEN;
                    out_byte   <= '0;
                    out_last   <= 1'b1;
                    out_used   <= USED_W'(used);
                  end else if (in_first && !space_ok) begin
                    // drop the rest of the run quietly
                    run_rem    <= in_len - LEN_W'(1);
                    run_acc    <= 1'b0;
                    out_status <= ST_NO_SPACE;
                    out_byte   <= '0;
                    out_last   <= 1'b1;
                    out_used   <= USED_W'(used);
                  end else if (wr_acc_e) begin
                    // store and advance; commit the pointer on the last byte
                    run_addr <= wr_addr_nx;
                    run_rem  <= wr_rem_e - LEN_W'(1);
                    if (wr_fin) begin
                      wptr    <= wr_addr_nx >> esz_log2;
                      run_acc <= 1'b0;
                      state   <= S_WDONE;
                    end else begin
                      run_acc <= 1'b1;
                    end
                  end else if (run_rem != '0) begin
                    run_rem <= run_rem - LEN_W'(1);
                  end
                end
                FN_READ, FN_PEEK: begin
                  if (bad_len) begin
                    out_status <= ST_BAD_LEN;
                    out_byte   <= '0;
                    out_last   <= 1'b1;
                    out_used   <= USED_W'(used);
                  end else if (!data_ok) begin
                    out_status <= ST_NO_DATA;
                    out_byte   <= '0;
                    out_last   <= 1'b1;
                    out_used   <= USED_W'(used);
                  end else begin
                    raddr     <= rbyte;
                    issue_rem <= in_len;
                    if (in_func == FN_READ) begin
                      rptr <= rd_end >> esz_log2;
                    end
                    state <= S_RD;
                  end
                end
                default: ;
              endcase
            end
          end
          S_WDONE: begin
            // report the finished run with the updated pointer
            out_status <= ST_OK;
            out_byte   <= '0;
            out_last   <= 1'b1;
            out_used   <= USED_W'(used);
            state      <= S_IDLE;
          end
          S_RD: begin
            // issue one store read a cycle while the holding slot allows
            if (rd_issue) begin
              raddr     <= next_addr(raddr, eff);
              issue_rem <= issue_rem - LEN_W'(1);
              rd_last   <= (issue_rem == LEN_W'(1));
            end
            if (rd_move) begin
              out_status <= ST_OK;
              out_byte   <= rd_q;
              out_last   <= rd_last;
              out_used   <= USED_W'(used);
            end
            rd_pend <= rd_issue || (rd_pend && !rd_move);
            if ((issue_rem == '0) && (!rd_pend || rd_move)) begin
              state <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // Result ports
  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_used, out_byte};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  // Checks
  `BRF_ASSERT(a_pend_in_read, rd_pend |-> (state == S_RD))
  `BRF_ASSERT(a_run_has_bytes, run_acc |-> (run_rem != '0))
  `BRF_ASSERT(a_err_single, (m_tvalid && (m_tuser != ST_OK)) |-> (m_tlast && (m_tdata[7:0] == '0)))
  `BRF_ASSERT_NEXT(a_wdone_result, state == S_WDONE, m_tvalid && m_tlast && (m_tuser == ST_OK))

endmodule
